// ===== src/sm3_pkg.sv =====
// Shared types, constants and helper functions of the SM3 hash engine.
package sm3_pkg;

  localparam int unsigned SM3_BLOCK_COUNT_BITS = 32;
  localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
  localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  SM3_PAD_BYTE = 8'h80;

  typedef logic [0:7][31:0] sm3_vars_t;

  localparam sm3_vars_t SM3_IV = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } sm3_state_e;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sm3_out_t;

  typedef struct packed {
    logic        wr_en;
    logic        shift;
    logic [3:0]  wr_idx;
    logic [31:0] wr_data;
  } sm3_sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } sm3_rnd_ctrl_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

  // Round constant rotated by the round number mod 32.
  function automatic logic [31:0] tj_rot(input logic [5:0] r);
    logic [31:0] t;
    t = (r < 6'd16) ? SM3_T_LOW : SM3_T_HIGH;
    return rol32(t, r[4:0]);
  endfunction

endpackage

// ===== src/sm3_msg_sched.sv =====
// Block buffer and sliding message expansion window of the SM3 engine.
module sm3_msg_sched
  import sm3_pkg::*;
(
  input  logic            clk_i,
  input  sm3_sched_ctrl_t ctrl_i,
  output logic [31:0]     w_j_o,
  output logic [31:0]     w_j4_o
);

  logic [31:0] win_q [16];
  logic [31:0] w_new;

  // Next expanded word from the current window W[j..j+15].
  assign w_new = p1(win_q[0] ^ win_q[7] ^ rol32(win_q[13], 5'd15))
                 ^ rol32(win_q[3], 5'd7) ^ win_q[10];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_new;
    end else if (ctrl_i.wr_en) begin
      win_q[ctrl_i.wr_idx] <= ctrl_i.wr_data;
    end
  end

  assign w_j_o  = win_q[0];
  assign w_j4_o = win_q[4];

endmodule

// ===== src/sm3_round.sv =====
// Working variables A..H and the shared SM3 compression round.
module sm3_round
  import sm3_pkg::*;
(
  input  logic          clk_i,
  input  sm3_rnd_ctrl_t ctrl_i,
  input  sm3_vars_t     chain_i,
  input  logic [31:0]   w_j_i,
  input  logic [31:0]   w_j4_i,
  output sm3_vars_t     v_o
);

  sm3_vars_t   v_q;
  sm3_vars_t   v_d;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    a12 = rol32(v_q[0], 5'd12);
    ss1 = rol32(a12 + v_q[4] + tj_rot(ctrl_i.rnd), 5'd7);
    ss2 = ss1 ^ a12;
    if (ctrl_i.rnd < 6'd16) begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
    tt1 = ff + v_q[3] + ss2 + (w_j_i ^ w_j4_i);
    tt2 = gg + v_q[7] + ss1 + w_j_i;
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = chain_i;
    end else if (ctrl_i.step) begin
      v_d[3] = v_q[2];
      v_d[2] = rol32(v_q[1], 5'd9);
      v_d[1] = v_q[0];
      v_d[0] = tt1;
      v_d[7] = v_q[6];
      v_d[6] = rol32(v_q[5], 5'd19);
      v_d[5] = v_q[4];
      v_d[4] = p0(tt2);
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

// ===== src/sm3_hash_engine.sv =====
// Top level of the SM3 hash engine: sequencer, padding, chaining and digest output.
//
// Feed the message as big-endian 32-bit words, first byte in bits 31:24, and mark
// the final word with last_word; only that word may carry fewer than four bytes
// (byte_count, values above four count as four, zero adds no bytes). A word that
// is not last is buffered, except every sixteenth, which starts a compression:
// the shared round unit runs one SM3 round per cycle in ST_COMP, then ST_FOLD
// folds the result into the chaining value. in_ready_o is low while a block is
// compressed or the message is closed. The last word starts padding: the rest of
// the block is filled one word per cycle, then its rounds start and it is
// compressed. When the length field does not fit, the whole of a second block is
// filled with padding and compressed as well. The eight digest words then leave
// on the output channel, word 0 first, digest_last on word 7, one per cycle while
// out_ready_i is high. After the eighth transaction the engine is back at the
// initial vector with an empty message. No clearing pass follows reset. The
// length field counts compressed blocks in BLOCK_COUNT_BITS bits and wraps beyond
// that.
module sm3_hash_engine
  import sm3_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT_BITS = SM3_BLOCK_COUNT_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sm3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sm3_out_t out_data_o
);

  sm3_state_e state_q, state_d;

  logic [3:0]  wib_q, wib_d;        // words buffered in the current block
  logic [4:0]  ptr_q, ptr_d;        // padding fill pointer, 16 means block full
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        fin_q, fin_d;        // closing the message
  logic        pad80_q, pad80_d;    // 0x80 marker still owed as a whole word
  logic        lhere_q, lhere_d;    // length field goes into the current block
  logic [63:0] bits_q, bits_d;
  logic [BLOCK_COUNT_BITS-1:0] blocks_q, blocks_d;
  sm3_vars_t   chain_q, chain_d;

  sm3_sched_ctrl_t sched_ctrl;
  sm3_rnd_ctrl_t   rnd_ctrl;
  sm3_vars_t       v;
  logic [31:0]     w_j, w_j4;

  logic        in_acc, out_acc;
  logic [2:0]  nb;
  logic [6:0]  len;
  logic [31:0] last_wd;
  logic [31:0] pad_wd;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Saturate byte count and form the closing word: kept bytes plus the marker when fewer than four bytes are kept.
  always_comb begin
    nb  = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;
    len = {1'b0, wib_q, 2'b00} + {4'b0, nb};
    case (nb)
      3'd0:    last_wd = {SM3_PAD_BYTE, 24'h0};
      3'd1:    last_wd = {in_data_i.message_word[31:24], SM3_PAD_BYTE, 16'h0};
      3'd2:    last_wd = {in_data_i.message_word[31:16], SM3_PAD_BYTE, 8'h0};
      3'd3:    last_wd = {in_data_i.message_word[31:8], SM3_PAD_BYTE};
      default: last_wd = in_data_i.message_word;
    endcase
  end

  // Fill word for the padding pointer: marker, length halves or zero.
  always_comb begin
    if (pad80_q) begin
      pad_wd = {SM3_PAD_BYTE, 24'h0};
    end else if (lhere_q && ptr_q == 5'd14) begin
      pad_wd = bits_q[63:32];
    end else if (lhere_q && ptr_q == 5'd15) begin
      pad_wd = bits_q[31:0];
    end else begin
      pad_wd = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.last_word) begin
            state_d = ST_PAD;
          end else if (wib_q == 4'd15) begin
            state_d = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        if (ptr_q == 5'd16) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lhere_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && oidx_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    wib_d      = wib_q;
    ptr_d      = ptr_q;
    rnd_d      = rnd_q;
    oidx_d     = oidx_q;
    fin_d      = fin_q;
    pad80_d    = pad80_q;
    lhere_d    = lhere_q;
    bits_d     = bits_q;
    blocks_d   = blocks_q;
    chain_d    = chain_q;
    sched_ctrl = '{wr_en: 1'b0, shift: 1'b0, wr_idx: wib_q, wr_data: last_wd};
    rnd_ctrl   = '{load: 1'b0, step: 1'b0, rnd: rnd_q};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          sched_ctrl.wr_en = 1'b1;
          if (in_data_i.last_word) begin
            ptr_d   = {1'b0, wib_q} + 5'd1;
            pad80_d = (nb == 3'd4);
            lhere_d = (len <= 7'd55);
            fin_d   = 1'b1;
            bits_d  = ({{(64-BLOCK_COUNT_BITS){1'b0}}, blocks_q} << 9)
                      + {54'h0, len, 3'b000};
          end else begin
            sched_ctrl.wr_data = in_data_i.message_word;
            wib_d = wib_q + 4'd1;
            if (wib_q == 4'd15) begin
              rnd_ctrl.load = 1'b1;
              rnd_d = '0;
            end
          end
        end
      end
      ST_PAD: begin
        if (ptr_q == 5'd16) begin
          rnd_ctrl.load = 1'b1;
          rnd_d = '0;
        end else begin
          sched_ctrl.wr_en   = 1'b1;
          sched_ctrl.wr_idx  = ptr_q[3:0];
          sched_ctrl.wr_data = pad_wd;
          pad80_d = 1'b0;
          ptr_d   = ptr_q + 5'd1;
        end
      end
      ST_COMP: begin
        rnd_ctrl.step    = 1'b1;
        sched_ctrl.shift = 1'b1;
        rnd_d = rnd_q + 6'd1;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] ^ v[i];
        end
        if (!fin_q) begin
          blocks_d = blocks_q + BLOCK_COUNT_BITS'(1);
        end else if (lhere_q) begin
          oidx_d = '0;
        end else begin
          ptr_d   = '0;
          lhere_d = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            // Drop back to an empty message at the initial vector.
            chain_d  = SM3_IV;
            blocks_d = '0;
            wib_d    = '0;
            fin_d    = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_data_o.digest_word = chain_q[oidx_q];
  assign out_data_o.digest_last = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wib_q    <= '0;
      ptr_q    <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      fin_q    <= 1'b0;
      pad80_q  <= 1'b0;
      lhere_q  <= 1'b0;
      blocks_q <= '0;
      chain_q  <= SM3_IV;
    end else begin
      state_q  <= state_d;
      wib_q    <= wib_d;
      ptr_q    <= ptr_d;
      rnd_q    <= rnd_d;
      oidx_q   <= oidx_d;
      fin_q    <= fin_d;
      pad80_q  <= pad80_d;
      lhere_q  <= lhere_d;
      blocks_q <= blocks_d;
      chain_q  <= chain_d;
    end
  end

  // Length in bits is payload, set before it is read.
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  sm3_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_j_o  (w_j),
    .w_j4_o (w_j4)
  );

  sm3_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (rnd_ctrl),
    .chain_i (chain_q),
    .w_j_i   (w_j),
    .w_j4_i  (w_j4),
    .v_o     (v)
  );

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while digest pending");

  a_comp_to_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("compression did not end after round 63");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |-> (ptr_q <= 5'd16 && fin_q))
    else $error("padding pointer out of range");

  a_digest_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.digest_last) |=>
      (chain_q == SM3_IV && blocks_q == '0 && wib_q == 4'd0 && state_q == ST_IDLE))
    else $error("engine not reinitialized after digest");

endmodule

// ===== test/sm3_digest_board_pkg.sv =====
// Scoreboard for the SM3 hash engine: a bit-exact digest predictor and its result queue.
package sm3_digest_board_pkg;
  import sm3_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Standard chaining start value and round constants, kept apart from the RTL package.
  localparam logic [0:7][31:0] START_CHAIN = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] ROUND_K_LO  = 32'h79CC4519;
  localparam logic [31:0] ROUND_K_HI  = 32'h7A879D8A;
  localparam logic [7:0]  MARKER_BYTE = 8'h80;

  class sm3_digest_board;
    logic [31:0] chain [8];
    logic [31:0] held_words [16];
    int unsigned held_count;
    logic [SM3_BLOCK_COUNT_BITS-1:0] blocks_absorbed;
    sm3_out_t digest_q [$];
    int unsigned failures;
    int unsigned results_seen;

    function new();
      failures = 0;
      results_seen = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
      held_count = 0;
      blocks_absorbed = '0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      int unsigned k;
      k = n % 32;
      return (x << k) | (x >> (32 - k));
    endfunction

    function logic [31:0] mix_p0(input logic [31:0] x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function logic [31:0] mix_p1(input logic [31:0] x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    // Run one 512-bit block through the 64 rounds and fold it into the chain.
    function void absorb(input logic [31:0] blk [16]);
      logic [31:0] w [68];
      logic [31:0] v [8];
      logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++)
        w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int r = 0; r < 64; r++) begin
        a12 = rotl(v[0], 12);
        ss1 = rotl(a12 + v[4] + rotl((r < 16) ? ROUND_K_LO : ROUND_K_HI, r), 7);
        ss2 = ss1 ^ a12;
        if (r < 16) begin
          ff = v[0] ^ v[1] ^ v[2];
          gg = v[4] ^ v[5] ^ v[6];
        end else begin
          ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
          gg = (v[4] & v[5]) | (~v[4] & v[6]);
        end
        tt1 = ff + v[3] + ss2 + (w[r] ^ w[r+4]);
        tt2 = gg + v[7] + ss1 + w[r];
        v[3] = v[2];
        v[2] = rotl(v[1], 9);
        v[1] = v[0];
        v[0] = tt1;
        v[7] = v[6];
        v[6] = rotl(v[5], 19);
        v[5] = v[4];
        v[4] = mix_p0(tt2);
      end
      for (int j = 0; j < 8; j++) chain[j] ^= v[j];
    endfunction

    // Take one accepted message word; a closing word queues the eight digest words.
    function void note_word(input sm3_in_t item);
      logic [7:0]  tail [128];
      logic [31:0] blk [16];
      logic [63:0] bit_len;
      int unsigned take, len, nblk;
      sm3_out_t    want;
      if (!item.last_word) begin
        held_words[held_count] = item.message_word;
        held_count++;
        if (held_count == 16) begin
          absorb(held_words);
          blocks_absorbed++;
          held_count = 0;
        end
        return;
      end
      take = (item.byte_count > 3'd4) ? 4 : item.byte_count;
      for (int i = 0; i < 128; i++) tail[i] = 8'h00;
      for (int i = 0; i < held_count; i++)
        for (int b = 0; b < 4; b++) tail[4*i+b] = held_words[i][31-8*b -: 8];
      len = 4 * held_count;
      for (int b = 0; b < take; b++) tail[len+b] = item.message_word[31-8*b -: 8];
      len += take;
      bit_len = (64'(blocks_absorbed) << 9) + (64'(len) << 3);
      tail[len] = MARKER_BYTE;
      nblk = (len + 9 <= 64) ? 1 : 2;
      for (int i = 0; i < 8; i++) tail[64*nblk-1-i] = bit_len[8*i +: 8];
      for (int k = 0; k < nblk; k++) begin
        for (int i = 0; i < 16; i++)
          blk[i] = {tail[64*k+4*i], tail[64*k+4*i+1], tail[64*k+4*i+2], tail[64*k+4*i+3]};
        absorb(blk);
      end
      for (int i = 0; i < 8; i++) begin
        want.digest_word = chain[i];
        want.digest_last = (i == 7);
        digest_q.push_back(want);
      end
      restart();
    endfunction

    function void flag(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    // Compare one accepted digest transaction with the oldest queued word.
    function void check_digest(input sm3_out_t got);
      sm3_out_t want;
      results_seen++;
      if (digest_q.size() == 0) begin
        flag($sformatf("result %0d unexpected: digest_word %h digest_last %0b",
                       results_seen, got.digest_word, got.digest_last));
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word)
        flag($sformatf("result %0d digest_word: expected %h got %h",
                       results_seen, want.digest_word, got.digest_word));
      if (got.digest_last !== want.digest_last)
        flag($sformatf("result %0d digest_last: expected %0b got %0b",
                       results_seen, want.digest_last, got.digest_last));
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

// ===== test/sm3_hash_engine_test.sv =====
// Self-checking testbench of the SM3 hash engine: directed and random messages.
module sm3_hash_engine_test;
  import sm3_pkg::*;
  import sm3_digest_board_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest legal run stays far below this; it only guards against a hang.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned IDLE_PCT     = 16;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sm3_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sm3_out_t out_data_o;

  // While set, neither side idles: a long back-to-back stretch.
  bit          no_idle;
  int unsigned cycle_count;
  int unsigned words_sent;

  sm3_digest_board digests;

  sm3_hash_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort the run on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the digest output at random, except during the back-to-back stretch.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check every digest transaction against the predictor; values seen here are the
  // ones the block sampled at this same edge, since all drives use nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) digests.check_digest(out_data_o);
  end

  // Offer one word, hold it until accepted, then hand it to the predictor. Valid is
  // only dropped for an idle gap, so back-to-back words never toggle it within a step.
  task automatic send_word(input sm3_in_t item);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    digests.note_word(item);
    words_sent++;
  endtask

  task automatic send_raw(input logic [31:0] word, input logic [2:0] count,
                          input logic last);
    sm3_in_t item;
    item.message_word = word;
    item.byte_count   = count;
    item.last_word    = last;
    send_word(item);
  endtask

  // Mostly random words, with some all-zero and all-one words mixed in.
  function automatic logic [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Send n_words full words, then a closing word with a random byte count.
  task automatic send_message(input int unsigned n_words);
    for (int i = 0; i < n_words; i++)
      send_raw(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_raw(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Favor lengths around the one-, two- and three-block padding boundaries.
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(0, 20);
    if (roll < 80) return $urandom_range(12, 17);
    if (roll < 95) return $urandom_range(28, 33);
    return $urandom_range(44, 50);
  endfunction

  initial begin
    int unsigned msg_idx;
    digests     = new();
    no_idle     = 1'b0;
    words_sent  = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message: a closing word with no bytes.
    send_raw(32'hDEAD_BEEF, 3'd0, 1'b1);
    // Three-byte message "abc".
    send_raw(32'h6162_6300, 3'd3, 1'b1);
    // Byte counts above four saturate to four.
    send_raw(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_raw(32'h0000_0000, 3'd5, 1'b1);
    send_raw(32'h0123_4567, 3'd6, 1'b1);
    // Closing word fills the block: data block first, padding in a fresh block.
    for (int i = 0; i < 15; i++)
      send_raw((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0);
    send_raw(32'hFFFF_FFFF, 3'd4, 1'b1);

    // Random messages; a run of them goes back to back on both channels.
    msg_idx = 0;
    while (words_sent < RANDOM_ITEMS + 20) begin
      no_idle = (msg_idx >= 8 && msg_idx < 14);
      send_message(pick_length());
      msg_idx++;
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding digests, then give the block time to show any stray result.
    while (digests.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (digests.failures == 0 && digests.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
